// File: rtl/fsa_pkg.sv
// fsa_pkg: shared types and codes of the fixed slot allocator
// command and status codes, channel payloads, controller/datapath handshake structs
// no dependencies

package fsa_pkg;

  // operation codes
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_RESIZE = 2'd3
  } fsa_cmd_code_t;

  // result codes
  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_BAD_SIZE   = 3'd1,
    STS_FULL       = 3'd2,
    STS_INACTIVE   = 3'd3,
    STS_RANGE      = 3'd4,
    STS_MISALIGNED = 3'd5,
    STS_NEEDS_MOVE = 3'd6,
    STS_NOT_ALLOC  = 3'd7
  } fsa_status_t;

  // request payload
  typedef struct packed {
    fsa_cmd_code_t cmd;
    logic [7:0]    req_size;
    logic [31:0]   address;
  } fsa_req_t;

  // response payload
  typedef struct packed {
    fsa_status_t status;
    logic [31:0] block_address;
    logic [7:0]  stored_size;
    logic [7:0]  live_blocks;
  } fsa_rsp_t;

  // step strobes from controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic fix;
    logic read;
    logic commit;
  } fsa_ctrl_t;

  // datapath status back to controller
  typedef struct packed {
    logic out_free;
  } fsa_stat_t;

endpackage

// File: rtl/fsa_if.sv
// fsa_if: valid/ready channel interfaces of the fixed slot allocator
// request and response channels; depends on fsa_pkg

interface fsa_req_if;
  logic              valid;
  logic              ready;
  fsa_pkg::fsa_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fsa_rsp_if;
  logic              valid;
  logic              ready;
  fsa_pkg::fsa_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/fsa_ram.sv
// fsa_ram: generic single write port, single read port RAM with registered read
// no dependencies

module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fsa_ctrl.sv
// fsa_ctrl: sequencer of the fixed slot allocator
// walks each command through load, calc, fix, read and commit; depends on fsa_pkg

module fsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fsa_pkg::fsa_stat_t stat,
  output fsa_pkg::fsa_ctrl_t ctrl
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_FIX  = 5'b00100,
    ST_READ = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and step strobes
  always_comb begin
    state_next  = state;
    ctrl        = '0;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        ctrl.calc  = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        ctrl.fix   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        ctrl.read  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          ctrl.commit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/fsa_dp.sv
// fsa_dp: datapath of the fixed slot allocator
// address decode, occupancy vector, size RAM, counters and output register
// depends on fsa_pkg and fsa_ram

module fsa_dp #(
  parameter int SLOT_COUNT = 128,
  parameter int SLOT_SIZE  = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  fsa_pkg::fsa_req_t  in_data,
  input  fsa_pkg::fsa_ctrl_t ctrl,
  output fsa_pkg::fsa_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output fsa_pkg::fsa_rsp_t  out_data
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RSH   = 24;
  localparam logic [31:0] SPAN  = 32'(SLOT_COUNT * SLOT_SIZE);
  localparam logic [24:0] RECIP = 25'((1 << RSH) / SLOT_SIZE);
  localparam logic [7:0]  SIZE8 = 8'(SLOT_SIZE);
  localparam logic [15:0] SIZE16 = 16'(SLOT_SIZE);

  // captured command
  fsa_pkg::fsa_cmd_code_t cmd_r;
  logic [7:0]             req_r;
  logic [31:0]            addr_r;
  logic [31:0]            offset;

  // decode results
  logic                   range_bad;
  logic [40:0]            qprod;
  logic [IDX_W-1:0]       free_idx;
  logic                   full;
  logic [IDX_W-1:0]       slot;
  logic                   misal;
  logic [15:0]            alloc_prod;
  logic [31:0]            alloc_addr;
  logic                   slot_used;

  // persistent state
  logic [31:0]            data_base;
  logic [SLOT_COUNT-1:0]  occ;
  logic [7:0]             live_count;
  logic                   zone_active;

  // combinational helpers
  logic [IDX_W-1:0]       free_idx_next;
  logic                   full_next;
  logic [7:0]             q_est;
  logic [15:0]            rem;
  logic [7:0]             q_fix;
  logic [15:0]            rem_fix;

  // ram
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [7:0]             ram_wdata;
  logic [7:0]             ram_rdata;

  // commit results
  fsa_pkg::fsa_status_t   sts;
  logic [31:0]            baddr;
  logic [7:0]             ssize;
  logic [7:0]             live_next;
  logic                   zone_next;
  logic                   occ_set;
  logic                   occ_clr;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      data_base <= '0;
    end else if (cfg_we) begin
      data_base <= cfg_wdata;
    end
  end

  // capture transfer and form the offset from the data base
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_data.cmd;
      req_r  <= in_data.req_size;
      addr_r <= in_data.address;
      offset <= in_data.address - data_base;
    end
  end

  // lowest free slot over the occupancy vector
  always_comb begin
    free_idx_next = '0;
    full_next     = 1'b1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        free_idx_next = IDX_W'(i);
        full_next     = 1'b0;
      end
    end
  end

  // range check, reciprocal product, free search
  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      range_bad <= (offset >= SPAN);
      qprod     <= 41'(offset[15:0]) * 41'(RECIP);
      free_idx  <= free_idx_next;
      full      <= full_next;
    end
  end

  // quotient correction: estimate is exact or one low
  always_comb begin
    q_est   = qprod[RSH +: 8];
    rem     = offset[15:0] - 16'(16'(q_est) * SIZE16);
    q_fix   = q_est;
    rem_fix = rem;
    if (rem >= SIZE16) begin
      q_fix   = q_est + 8'd1;
      rem_fix = rem - SIZE16;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fix) begin
      slot       <= q_fix[IDX_W-1:0];
      misal      <= (rem_fix != 16'd0);
      alloc_prod <= 16'(free_idx) * SIZE16;
    end
  end

  // slot lookup and alloc address
  always_ff @(posedge clk) begin
    if (ctrl.read) begin
      alloc_addr <= data_base + 32'(alloc_prod);
      slot_used  <= occ[slot];
    end
  end

  fsa_ram #(
    .WIDTH(8),
    .DEPTH(SLOT_COUNT)
  ) u_size_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ctrl.read),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  // command outcome
  always_comb begin
    sts       = fsa_pkg::STS_OK;
    baddr     = '0;
    ssize     = '0;
    live_next = live_count;
    zone_next = zone_active;
    occ_set   = 1'b0;
    occ_clr   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = req_r;
    if (cmd_r == fsa_pkg::CMD_ALLOC) begin
      ram_waddr = free_idx;
      if (req_r == 8'd0 || req_r > SIZE8) begin
        sts = fsa_pkg::STS_BAD_SIZE;
      end else begin
        zone_next = 1'b1;
        if (full) begin
          sts = fsa_pkg::STS_FULL;
        end else begin
          occ_set   = 1'b1;
          ram_we    = ctrl.commit;
          live_next = live_count + 8'd1;
          baddr     = alloc_addr;
        end
      end
    end else if (!zone_active) begin
      sts = fsa_pkg::STS_INACTIVE;
    end else if (range_bad) begin
      sts = fsa_pkg::STS_RANGE;
    end else if (cmd_r == fsa_pkg::CMD_RESIZE && req_r == 8'd0) begin
      sts = fsa_pkg::STS_BAD_SIZE;
    end else if (misal) begin
      sts = fsa_pkg::STS_MISALIGNED;
    end else if (!slot_used) begin
      sts = fsa_pkg::STS_NOT_ALLOC;
    end else begin
      case (cmd_r)
        fsa_pkg::CMD_FREE: begin
          occ_clr   = 1'b1;
          live_next = live_count - 8'd1;
          if (live_count == 8'd1) begin
            zone_next = 1'b0;
          end
        end
        fsa_pkg::CMD_QUERY: begin
          ssize = ram_rdata;
        end
        default: begin
          if (req_r > SIZE8) begin
            sts   = fsa_pkg::STS_NEEDS_MOVE;
            ssize = ram_rdata;
          end else begin
            ram_we = ctrl.commit;
            baddr  = addr_r;
          end
        end
      endcase
    end
  end

  // persistent state update
  always_ff @(posedge clk) begin
    if (rst) begin
      occ         <= '0;
      live_count  <= '0;
      zone_active <= 1'b0;
    end else if (ctrl.commit) begin
      live_count  <= live_next;
      zone_active <= zone_next;
      if (occ_set) begin
        occ[free_idx] <= 1'b1;
      end
      if (occ_clr) begin
        occ[slot] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_data.status        <= sts;
      out_data.block_address <= baddr;
      out_data.stored_size   <= ssize;
      out_data.live_blocks   <= live_next;
    end
  end

  assign stat.out_free  = !out_valid || out_ready;

endmodule

// File: rtl/fixed_slot_allocator_unit.sv
// fixed_slot_allocator_unit: top level of the fixed slot allocator
// joins fsa_ctrl and fsa_dp; depends on fsa_pkg, fsa_if, fsa_ram, fsa_ctrl, fsa_dp
//
//   channel    role    signals                  moves
//   request    sink    valid ready payload      cmd, req_size, address
//   response   source  valid ready payload      status, block_address, stored_size,
//                                               live_blocks
//   config     write   cfg_we cfg_wdata         data_base
//
// the offset subtract happens at the request transfer; the result is registered
// after range check with reciprocal product and free search, quotient fix,
// size RAM read and commit; the next request can transfer once commit returns to idle;
// a new request is taken while the previous result waits in the output register;
// the commit step stalls while that register is still full
// reset clears the occupancy vector, live count and zone flag at once; no clearing pass

module fixed_slot_allocator_unit #(
  parameter int SLOT_COUNT = 128,
  parameter int SLOT_SIZE  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  fsa_req_if.sink     request,
  fsa_rsp_if.source   response
);

  fsa_pkg::fsa_ctrl_t ctrl;
  fsa_pkg::fsa_stat_t stat;
  logic               in_ready;
  logic               out_valid;
  fsa_pkg::fsa_rsp_t  out_data;

  fsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(request.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  fsa_dp #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_SIZE (SLOT_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_data  (request.payload),
    .ctrl     (ctrl),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(response.ready),
    .out_data (out_data)
  );

  // channel hookup
  assign request.ready    = in_ready;
  assign response.valid   = out_valid;
  assign response.payload = out_data;

endmodule
